// ===== design/ldp_pkg.sv =====
// ----------------------------------------------------------------------------
// ldp_pkg : shared types, constants and saturation helpers
// Register map, configuration bundle, the radial-to-tangential beat and the
// clamp functions used by both sections of the distortion pipeline.
// ----------------------------------------------------------------------------
package ldp_pkg;

    // Pipeline depth of ldp_mul64, in register stages.
    localparam int MUL_LAT = 3;

    localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;

    typedef enum logic [2:0] {
        CFG_ENABLE       = 3'd0,
        CFG_CENTRE_X     = 3'd1,
        CFG_CENTRE_Y     = 3'd2,
        CFG_RADIAL_ONE   = 3'd3,
        CFG_RADIAL_TWO   = 3'd4,
        CFG_RADIAL_THREE = 3'd5,
        CFG_TANGENT_ONE  = 3'd6,
        CFG_TANGENT_TWO  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic               enable;
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [63:0] radial_one;
        logic signed [63:0] radial_two;
        logic signed [63:0] radial_three;
        logic signed [63:0] tangent_one;
        logic signed [63:0] tangent_two;
    } t_cfg;

    // One beat leaving the radial section.
    typedef struct packed {
        logic               en;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] xr;
        logic signed [31:0] yr;
        logic               sat;
    } t_rad;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } t_clip;

    // Clamp a 128-bit value to signed 64 bits.
    function automatic logic signed [63:0] sat64_128(input logic signed [127:0] v);
        logic signed [63:0] res;
        if ((&v[127:63]) || !(|v[127:63])) begin
            res = v[63:0];
        end else begin
            res = v[127] ? S64_MIN : S64_MAX;
        end
        return res;
    endfunction

    // Saturating signed 64-bit add.
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] res;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            res = s[64] ? S64_MIN : S64_MAX;
        end else begin
            res = s[63:0];
        end
        return res;
    endfunction

    // Clip a 128-bit value to Q16.16 and report whether it was clipped.
    function automatic t_clip clip32_128(input logic signed [127:0] v);
        t_clip res;
        if ((&v[127:31]) || !(|v[127:31])) begin
            res.sat = 1'b0;
            res.val = v[31:0];
        end else begin
            res.sat = 1'b1;
            res.val = v[127] ? Q_MIN : Q_MAX;
        end
        return res;
    endfunction

endpackage

// ===== design/ldp_mul64.sv =====
// ----------------------------------------------------------------------------
// ldp_mul64 : three-stage signed 64x64 multiplier
// Splits both operands into 32-bit halves, forms four partial products,
// then merges the cross terms and adds them onto the outer terms.
// ----------------------------------------------------------------------------
module ldp_mul64 (
    input  logic                i_clk,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output logic signed [127:0] o_p
);

    logic signed [32:0]  a_lo;
    logic signed [32:0]  a_hi;
    logic signed [32:0]  b_lo;
    logic signed [32:0]  b_hi;
    logic signed [65:0]  n_p00;
    logic signed [65:0]  n_p01;
    logic signed [65:0]  n_p10;
    logic signed [65:0]  n_p11;
    logic signed [66:0]  n_mid;
    logic [63:0]         r_p00;
    logic signed [65:0]  r_p01;
    logic signed [65:0]  r_p10;
    logic signed [63:0]  r_p11;
    logic signed [66:0]  r_mid;
    logic [127:0]        r_hilo;
    logic signed [127:0] r_p;

    // Low halves are unsigned, high halves carry the sign.
    assign a_lo = {1'b0, i_a[31:0]};
    assign a_hi = {i_a[63], i_a[63:32]};
    assign b_lo = {1'b0, i_b[31:0]};
    assign b_hi = {i_b[63], i_b[63:32]};

    always_comb begin
        n_p00 = a_lo * b_lo;
        n_p01 = a_lo * b_hi;
        n_p10 = a_hi * b_lo;
        n_p11 = a_hi * b_hi;
        n_mid = {r_p01[65], r_p01} + {r_p10[65], r_p10};
    end

    always_ff @(posedge i_clk) begin
        r_p00  <= n_p00[63:0];
        r_p01  <= n_p01;
        r_p10  <= n_p10;
        r_p11  <= n_p11[63:0];
        r_mid  <= n_mid;
        r_hilo <= {r_p11, r_p00};
        r_p    <= r_hilo + {{29{r_mid[66]}}, r_mid, 32'd0};
    end

    assign o_p = r_p;

endmodule

// ===== design/ldp_radial.sv =====
// ----------------------------------------------------------------------------
// ldp_radial : radial section of the distortion pipeline
// Squared radius, Horner evaluation of the radial polynomial and scaling
// of the point, one beat per cycle.
// ----------------------------------------------------------------------------
module ldp_radial (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ldp_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    output logic               o_valid,
    output ldp_pkg::t_rad      o_rad
);

    // Stage at which each value is registered, counted from the input stage.
    localparam int ST_R     = 2;
    localparam int ST_A2    = ST_R + ldp_pkg::MUL_LAT + 1;
    localparam int ST_A1    = ST_A2 + ldp_pkg::MUL_LAT + 1;
    localparam int ST_K     = ST_A1 + ldp_pkg::MUL_LAT + 1;
    localparam int ST_XR    = ST_K + ldp_pkg::MUL_LAT + 1;
    localparam int DEPTH    = ST_XR + 1;
    localparam int RD_DEPTH = ST_A1 - ST_R + 1;

    typedef struct packed {
        logic               en;
        logic signed [31:0] x;
        logic signed [31:0] y;
    } t_car;

    logic [DEPTH-1:0]    r_v;
    t_car                r_car [DEPTH];
    logic signed [32:0]  r_dx;
    logic signed [32:0]  r_dy;
    logic [63:0]         r_dxx;
    logic [63:0]         r_dyy;
    logic [48:0]         r_rd [RD_DEPTH];
    logic signed [63:0]  r_a2;
    logic signed [63:0]  r_a1;
    logic signed [63:0]  r_k;
    logic signed [31:0]  r_xr;
    logic signed [31:0]  r_yr;
    logic                r_sat;

    logic signed [65:0]  n_dxx;
    logic signed [65:0]  n_dyy;
    logic [64:0]         n_rsum;
    logic signed [63:0]  n_a2;
    logic signed [63:0]  n_a1;
    logic signed [63:0]  n_k;
    ldp_pkg::t_clip      n_cx;
    ldp_pkg::t_clip      n_cy;

    logic signed [127:0] mul_a2;
    logic signed [127:0] mul_a1;
    logic signed [127:0] mul_k;
    logic signed [127:0] mul_x;
    logic signed [127:0] mul_y;

    // Horner step k3*R
    ldp_mul64 u_mul_a2 (
        .i_clk (i_clk),
        .i_a   (i_cfg.radial_three),
        .i_b   ({15'd0, r_rd[0]}),
        .o_p   (mul_a2)
    );

    // Horner step a2*R
    ldp_mul64 u_mul_a1 (
        .i_clk (i_clk),
        .i_a   (r_a2),
        .i_b   ({15'd0, r_rd[ST_A2-ST_R]}),
        .o_p   (mul_a1)
    );

    // Horner step a1*R
    ldp_mul64 u_mul_k (
        .i_clk (i_clk),
        .i_a   (r_a1),
        .i_b   ({15'd0, r_rd[ST_A1-ST_R]}),
        .o_p   (mul_k)
    );

    ldp_mul64 u_mul_x (
        .i_clk (i_clk),
        .i_a   ({{32{r_car[ST_K].x[31]}}, r_car[ST_K].x}),
        .i_b   (r_k),
        .o_p   (mul_x)
    );

    ldp_mul64 u_mul_y (
        .i_clk (i_clk),
        .i_a   ({{32{r_car[ST_K].y[31]}}, r_car[ST_K].y}),
        .i_b   (r_k),
        .o_p   (mul_y)
    );

    always_comb begin
        n_dxx  = r_dx * r_dx;
        n_dyy  = r_dy * r_dy;
        n_rsum = {1'b0, r_dxx} + {1'b0, r_dyy};
        n_a2   = ldp_pkg::sat_add64(i_cfg.radial_two, ldp_pkg::sat64_128(mul_a2 >>> 48));
        n_a1   = ldp_pkg::sat_add64(i_cfg.radial_one, ldp_pkg::sat64_128(mul_a1 >>> 48));
        n_k    = ldp_pkg::sat_add64(ldp_pkg::ONE_Q32, ldp_pkg::sat64_128(mul_k >>> 24));
        n_cx   = ldp_pkg::clip32_128(mul_x >>> 32);
        n_cy   = ldp_pkg::clip32_128(mul_y >>> 32);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_car[0].en <= i_cfg.enable;
        r_car[0].x  <= i_x;
        r_car[0].y  <= i_y;
        for (int i = 1; i < DEPTH; i++) begin
            r_car[i] <= r_car[i-1];
        end
        r_dx     <= {i_x[31], i_x} - {i_cfg.centre_x[31], i_cfg.centre_x};
        r_dy     <= {i_y[31], i_y} - {i_cfg.centre_y[31], i_cfg.centre_y};
        r_dxx    <= n_dxx[63:0];
        r_dyy    <= n_dyy[63:0];
        // floor of the exact sum over 2^16
        r_rd[0]  <= n_rsum[64:16];
        for (int i = 1; i < RD_DEPTH; i++) begin
            r_rd[i] <= r_rd[i-1];
        end
        r_a2     <= n_a2;
        r_a1     <= n_a1;
        r_k      <= n_k;
        r_xr     <= n_cx.val;
        r_yr     <= n_cy.val;
        r_sat    <= n_cx.sat | n_cy.sat;
    end

    always_comb begin
        o_valid   = r_v[DEPTH-1];
        o_rad.en  = r_car[ST_XR].en;
        o_rad.x   = r_car[ST_XR].x;
        o_rad.y   = r_car[ST_XR].y;
        o_rad.xr  = r_xr;
        o_rad.yr  = r_yr;
        o_rad.sat = r_sat;
    end

endmodule

// ===== design/ldp_tangent.sv =====
// ----------------------------------------------------------------------------
// ldp_tangent : tangential section and output stage
// Recomputes the squared radius of the scaled point, forms the p1/p2
// terms, adds them with saturation and selects the bypass when disabled.
// ----------------------------------------------------------------------------
module ldp_tangent (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ldp_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  ldp_pkg::t_rad      i_rad,
    output logic               o_valid,
    output logic signed [31:0] o_x,
    output logic signed [31:0] o_y,
    output logic               o_sat
);

    localparam int ST_U   = 3;
    localparam int ST_T   = ST_U + ldp_pkg::MUL_LAT + 2;
    localparam int ST_OUT = ST_T + 1;

    logic [ST_OUT:0]     r_v;
    ldp_pkg::t_rad       r_tc [ST_OUT];
    logic signed [32:0]  r_dx;
    logic signed [32:0]  r_dy;
    logic [63:0]         r_dxx;
    logic [63:0]         r_dyy;
    logic signed [63:0]  r_pxy;
    logic signed [63:0]  r_pxx;
    logic signed [63:0]  r_pyy;
    logic [48:0]         r_rt;
    logic signed [48:0]  r_xy2;
    logic [48:0]         r_sx2;
    logic [48:0]         r_sy2;
    logic [49:0]         r_ux;
    logic [49:0]         r_uy;
    logic signed [48:0]  r_xy2d;
    logic signed [127:0] r_sumx;
    logic signed [127:0] r_sumy;
    logic signed [63:0]  r_tx;
    logic signed [63:0]  r_ty;
    logic signed [31:0]  r_ox;
    logic signed [31:0]  r_oy;
    logic                r_osat;

    logic signed [65:0]  n_dxx;
    logic signed [65:0]  n_dyy;
    logic signed [63:0]  n_pxy;
    logic signed [63:0]  n_pxx;
    logic signed [63:0]  n_pyy;
    logic [64:0]         n_rsum;
    ldp_pkg::t_clip      n_fx;
    ldp_pkg::t_clip      n_fy;
    ldp_pkg::t_rad       car_t;

    logic signed [63:0]  xy2_ext;
    logic signed [127:0] mul_xa;
    logic signed [127:0] mul_xb;
    logic signed [127:0] mul_ya;
    logic signed [127:0] mul_yb;

    assign xy2_ext = {{15{r_xy2d[48]}}, r_xy2d};
    assign car_t   = r_tc[ST_T];

    ldp_mul64 u_mul_xa (
        .i_clk (i_clk),
        .i_a   (i_cfg.tangent_one),
        .i_b   (xy2_ext),
        .o_p   (mul_xa)
    );

    ldp_mul64 u_mul_xb (
        .i_clk (i_clk),
        .i_a   (i_cfg.tangent_two),
        .i_b   ({14'd0, r_ux}),
        .o_p   (mul_xb)
    );

    ldp_mul64 u_mul_ya (
        .i_clk (i_clk),
        .i_a   (i_cfg.tangent_two),
        .i_b   (xy2_ext),
        .o_p   (mul_ya)
    );

    ldp_mul64 u_mul_yb (
        .i_clk (i_clk),
        .i_a   (i_cfg.tangent_one),
        .i_b   ({14'd0, r_uy}),
        .o_p   (mul_yb)
    );

    always_comb begin
        n_dxx  = r_dx * r_dx;
        n_dyy  = r_dy * r_dy;
        n_pxy  = r_tc[0].xr * r_tc[0].yr;
        n_pxx  = r_tc[0].xr * r_tc[0].xr;
        n_pyy  = r_tc[0].yr * r_tc[0].yr;
        n_rsum = {1'b0, r_dxx} + {1'b0, r_dyy};
        // both sums stay far below 2^127, so no carry bit is kept
        n_fx   = ldp_pkg::clip32_128({{96{car_t.xr[31]}}, car_t.xr}
                                     + {{64{r_tx[63]}}, r_tx});
        n_fy   = ldp_pkg::clip32_128({{96{car_t.yr[31]}}, car_t.yr}
                                     + {{64{r_ty[63]}}, r_ty});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[ST_OUT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tc[0] <= i_rad;
        for (int i = 1; i < ST_OUT; i++) begin
            r_tc[i] <= r_tc[i-1];
        end
        r_dx   <= {i_rad.xr[31], i_rad.xr} - {i_cfg.centre_x[31], i_cfg.centre_x};
        r_dy   <= {i_rad.yr[31], i_rad.yr} - {i_cfg.centre_y[31], i_cfg.centre_y};
        r_dxx  <= n_dxx[63:0];
        r_dyy  <= n_dyy[63:0];
        r_pxy  <= n_pxy;
        r_pxx  <= n_pxx;
        r_pyy  <= n_pyy;
        r_rt   <= n_rsum[64:16];
        // twice the floored products
        r_xy2  <= {r_pxy[63:16], 1'b0};
        r_sx2  <= {r_pxx[63:16], 1'b0};
        r_sy2  <= {r_pyy[63:16], 1'b0};
        r_ux   <= {1'b0, r_rt} + {1'b0, r_sx2};
        r_uy   <= {1'b0, r_rt} + {1'b0, r_sy2};
        r_xy2d <= r_xy2;
        r_sumx <= mul_xa + mul_xb;
        r_sumy <= mul_ya + mul_yb;
        r_tx   <= ldp_pkg::sat64_128(r_sumx >>> 40);
        r_ty   <= ldp_pkg::sat64_128(r_sumy >>> 40);
        // pass the point straight through when disabled
        if (car_t.en) begin
            r_ox   <= n_fx.val;
            r_oy   <= n_fy.val;
            r_osat <= car_t.sat | n_fx.sat | n_fy.sat;
        end else begin
            r_ox   <= car_t.x;
            r_oy   <= car_t.y;
            r_osat <= 1'b0;
        end
    end

    assign o_valid = r_v[ST_OUT];
    assign o_x     = r_ox;
    assign o_y     = r_oy;
    assign o_sat   = r_osat;

endmodule

// ===== design/lens_distortion_polynomial_top.sv =====
// ----------------------------------------------------------------------------
// lens_distortion_polynomial_top : radial and tangential lens distortion
// Distorts one Q16.16 pixel point per clock with a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a point beat is taken at each rising edge with start high and busy
//   low. busy is held low: the pipeline takes a new point every cycle.
//   Output: each result beat is shown for exactly one cycle with o_strobe
//   high. Results leave in order, one per accepted point, one per cycle
//   at full rate. The receiver cannot stall; the pipeline never holds a
//   beat back.
//   Latency comes from five multiply segments in series (three Horner steps,
//   the radial scale and the tangential products), each a three-stage split
//   64x64 multiplier, plus the radius, clamp and add stages around them.
//   Configuration: write a register with i_cfg_we, i_cfg_index, i_cfg_data
//   while no point is in flight. The enable bit is sampled with each point.
//   Reset: synchronous and active low; clears the configuration registers to
//   zero (distortion off) and drops every beat in flight. No clearing pass.
// ----------------------------------------------------------------------------
module lens_distortion_polynomial_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // point channel
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    // result channel
    output logic               o_strobe,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic               o_saturated,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    ldp_pkg::t_cfg r_cfg;
    ldp_pkg::t_cfg n_cfg;
    ldp_pkg::t_rad rad;
    logic          rad_valid;
    logic          in_beat;

    // Hold busy low: every stage advances each cycle.
    assign busy    = 1'b0;
    assign in_beat = start && !busy;

    // Register write decode; all eight indexes map to a register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (ldp_pkg::t_cfg_idx'(i_cfg_index))
                ldp_pkg::CFG_ENABLE:       n_cfg.enable       = i_cfg_data[0];
                ldp_pkg::CFG_CENTRE_X:     n_cfg.centre_x     = i_cfg_data[31:0];
                ldp_pkg::CFG_CENTRE_Y:     n_cfg.centre_y     = i_cfg_data[31:0];
                ldp_pkg::CFG_RADIAL_ONE:   n_cfg.radial_one   = i_cfg_data;
                ldp_pkg::CFG_RADIAL_TWO:   n_cfg.radial_two   = i_cfg_data;
                ldp_pkg::CFG_RADIAL_THREE: n_cfg.radial_three = i_cfg_data;
                ldp_pkg::CFG_TANGENT_ONE:  n_cfg.tangent_one  = i_cfg_data;
                ldp_pkg::CFG_TANGENT_TWO:  n_cfg.tangent_two  = i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Radial section: squared radius, polynomial, scaled point.
    ldp_radial u_radial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (in_beat),
        .i_x     (i_point_x),
        .i_y     (i_point_y),
        .o_valid (rad_valid),
        .o_rad   (rad)
    );

    // Tangential section drives the registered result beat directly.
    ldp_tangent u_tangent (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (rad_valid),
        .i_rad   (rad),
        .o_valid (o_strobe),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_sat   (o_saturated)
    );

endmodule

// ===== tb/tb_lens_distortion_polynomial_top.sv =====
// ----------------------------------------------------------------------------
// tb_lens_distortion_polynomial_top : self-checking bench for the lens distorter
// Drives point beats through the start/busy port and predicts each distorted
// point with a 128-bit model of the fixed-point pipeline (radius, Horner
// polynomial, radial scale, tangential terms, clamps). Every o_strobe beat is
// checked field by field against the oldest prediction. Directed tests cover
// pass-through, radial and tangential extremes and centre offsets. Random
// streams then run under several coefficient sets and sender gap rates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lens_distortion_polynomial_top;

    // Wide signed working type: every product and sum of the datapath fits.
    typedef logic signed [127:0] t_wide;

    localparam t_wide W64_HI = 128'sh0000_0000_0000_0000_7fff_ffff_ffff_ffff;
    localparam t_wide W64_LO = -W64_HI - 1;
    localparam t_wide WQ_HI  = 128'sh0000_0000_0000_0000_0000_0000_7fff_ffff;
    localparam t_wide WQ_LO  = -WQ_HI - 1;

    // Shadow of the register file, updated whenever the bench writes it.
    typedef struct {
        bit                 enable;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [63:0] k1;
        logic signed [63:0] k2;
        logic signed [63:0] k3;
        logic signed [63:0] p1;
        logic signed [63:0] p2;
    } t_lens_setting;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } t_distorted_point;

    typedef enum {
        SET_OFF,
        SET_TYPICAL,
        SET_TANGENT_ONLY,
        SET_HIGHEST,
        SET_LOWEST,
        SET_WILD
    } t_setting_kind;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic               o_strobe;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic               o_saturated;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;

    t_lens_setting      lens;
    t_distorted_point   distorted_due[$];
    int                 fail_count;
    int                 sender_idle_pct;

    lens_distortion_polynomial_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_strobe    (o_strobe),
        .o_out_x     (o_out_x),
        .o_out_y     (o_out_y),
        .o_saturated (o_saturated),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Fixed-point model of the distortion
    // ------------------------------------------------------------------------

    function automatic t_wide clamp64(input t_wide v);
        if (v > W64_HI) return W64_HI;
        if (v < W64_LO) return W64_LO;
        return v;
    endfunction

    function automatic t_wide clip_q(input t_wide v);
        if (v > WQ_HI) return WQ_HI;
        if (v < WQ_LO) return WQ_LO;
        return v;
    endfunction

    // Floor of a*b / 2^s.
    function automatic t_wide shr_mul(input t_wide a, input t_wide b, input int s);
        return (a * b) >>> s;
    endfunction

    function automatic t_wide mul_shift(input t_wide a, input t_wide b, input int s);
        return clamp64(shr_mul(a, b, s));
    endfunction

    // Squared distance to the centre in units of 2^-16 px^2, exact then floored.
    function automatic t_wide sq_dist(input logic signed [31:0] px,
                                      input logic signed [31:0] py);
        t_wide dx;
        t_wide dy;
        dx = t_wide'(px);
        dy = t_wide'(py);
        dx = dx - t_wide'(lens.cx);
        dy = dy - t_wide'(lens.cy);
        return (dx * dx + dy * dy) >>> 16;
    endfunction

    function automatic t_distorted_point distort_point(input logic signed [31:0] px,
                                                       input logic signed [31:0] py);
        t_distorted_point res;
        t_wide r, a2, a1, k, xs, ys, xr, yr, rt, xy2, sx, sy, tsum, tx, ty, fx, fy;
        logic  clipped;
        if (!lens.enable) begin
            res.x   = px;
            res.y   = py;
            res.sat = 1'b0;
            return res;
        end
        // Horner evaluation of 1 + k1*R + k2*R^2 + k3*R^3 in Q31.32
        r  = sq_dist(px, py);
        a2 = clamp64(t_wide'(lens.k2) + mul_shift(t_wide'(lens.k3), r, 48));
        a1 = clamp64(t_wide'(lens.k1) + mul_shift(a2, r, 48));
        k  = clamp64(t_wide'(ldp_pkg::ONE_Q32) + mul_shift(a1, r, 24));
        // Scale the point itself, then clip to Q16.16
        xs = shr_mul(t_wide'(px), k, 32);
        ys = shr_mul(t_wide'(py), k, 32);
        xr = clip_q(xs);
        yr = clip_q(ys);
        clipped = (xr != xs) || (yr != ys);
        // Tangential terms from the clipped radial point
        rt   = sq_dist(xr[31:0], yr[31:0]);
        xy2  = 2 * mul_shift(xr, yr, 16);
        sx   = mul_shift(xr, xr, 16);
        sy   = mul_shift(yr, yr, 16);
        tsum = t_wide'(lens.p1) * xy2 + t_wide'(lens.p2) * (rt + 2 * sx);
        tx   = clamp64(tsum >>> 40);
        tsum = t_wide'(lens.p2) * xy2 + t_wide'(lens.p1) * (rt + 2 * sy);
        ty   = clamp64(tsum >>> 40);
        fx   = clamp64(xr + tx);
        fy   = clamp64(yr + ty);
        res.x   = 32'(clip_q(fx));
        res.y   = 32'(clip_q(fy));
        res.sat = clipped || (clip_q(fx) != fx) || (clip_q(fy) != fy);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus generators
    // ------------------------------------------------------------------------

    function automatic logic signed [31:0] q16(input int whole);
        return whole <<< 16;
    endfunction

    // Coefficient of random sign with a magnitude below 2^(bits+3).
    function automatic logic signed [63:0] rand_coef(input int bits);
        logic signed [63:0] v;
        int                 w;
        w = $urandom_range(bits + 3);
        v = {$urandom, $urandom};
        v = v & ((64'sd1 <<< w) - 1);
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    // Mostly points within 4096 px of the origin on each axis, with raw words and extremes mixed in.
    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        case ($urandom_range(15))
            0: v = $urandom;
            1: begin
                case ($urandom_range(3))
                    0:       v = ldp_pkg::Q_MAX;
                    1:       v = ldp_pkg::Q_MIN;
                    2:       v = 32'sd0;
                    default: v = -32'sd1;
                endcase
            end
            default: begin
                v = $urandom_range(32'h0fff_ffff);
                if ($urandom_range(1)) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic t_lens_setting rand_setting(input t_setting_kind kind);
        t_lens_setting s;
        s.enable = 1'b1;
        s.cx     = $urandom_range(32'h07ff_ffff);
        s.cy     = $urandom_range(32'h07ff_ffff);
        s.k1     = rand_coef(18);
        s.k2     = rand_coef(30);
        s.k3     = rand_coef(42);
        s.p1     = rand_coef(20);
        s.p2     = rand_coef(20);
        case (kind)
            SET_OFF: s.enable = 1'b0;
            SET_TANGENT_ONLY: begin
                s.k1 = '0;
                s.k2 = '0;
                s.k3 = '0;
            end
            SET_HIGHEST: begin
                s.cx = ldp_pkg::Q_MAX;
                s.cy = ldp_pkg::Q_MAX;
                s.k1 = ldp_pkg::S64_MAX;
                s.k2 = ldp_pkg::S64_MAX;
                s.k3 = ldp_pkg::S64_MAX;
                s.p1 = ldp_pkg::S64_MAX;
                s.p2 = ldp_pkg::S64_MAX;
            end
            SET_LOWEST: begin
                s.cx = ldp_pkg::Q_MIN;
                s.cy = ldp_pkg::Q_MIN;
                s.k1 = ldp_pkg::S64_MIN;
                s.k2 = ldp_pkg::S64_MIN;
                s.k3 = ldp_pkg::S64_MIN;
                s.p1 = ldp_pkg::S64_MIN;
                s.p2 = ldp_pkg::S64_MIN;
            end
            SET_WILD: begin
                s.cx = $urandom;
                s.cy = $urandom;
                s.k1 = {$urandom, $urandom};
                s.k2 = {$urandom, $urandom};
                s.k3 = {$urandom, $urandom};
                s.p1 = {$urandom, $urandom};
                s.p2 = {$urandom, $urandom};
            end
            default: ;
        endcase
        return s;
    endfunction

    // ------------------------------------------------------------------------
    // Bus tasks
    // ------------------------------------------------------------------------

    // Leave the write enable high; set_lens drops it after the last register.
    task automatic write_reg(input ldp_pkg::t_cfg_idx idx, input logic [63:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Write every register; only call with the pipeline empty.
    // Fill unused upper bits with noise: the block must ignore them.
    task automatic set_lens(input t_lens_setting s);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(ldp_pkg::CFG_ENABLE,       {junk[63:1], s.enable});
        write_reg(ldp_pkg::CFG_CENTRE_X,     {junk[63:32], s.cx});
        write_reg(ldp_pkg::CFG_CENTRE_Y,     {junk[31:0], s.cy});
        write_reg(ldp_pkg::CFG_RADIAL_ONE,   s.k1);
        write_reg(ldp_pkg::CFG_RADIAL_TWO,   s.k2);
        write_reg(ldp_pkg::CFG_RADIAL_THREE, s.k3);
        write_reg(ldp_pkg::CFG_TANGENT_ONE,  s.p1);
        write_reg(ldp_pkg::CFG_TANGENT_TWO,  s.p2);
        i_cfg_we <= 1'b0;
        lens = s;
    endtask

    // Send one point beat. Start stays high on return so that back-to-back
    // beats never lower and raise it in the same step; drain() drops it.
    task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_point_x <= x;
        i_point_y <= y;
        do @(posedge i_clk); while (busy);
        distorted_due.push_back(distort_point(x, y));
    endtask

    // Drop start and hold until every predicted point has come back.
    task automatic drain();
        start <= 1'b0;
        while (distorted_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("ERROR at %0t: %s: wanted %h, got %h", $realtime, what, want, got);
        fail_count++;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: the receiver cannot stall, so take every strobe beat.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_distorted_point due;
        if (i_rst_n && o_strobe) begin
            if (distorted_due.size() == 0) begin
                report_mismatch("result with no point pending", '0, o_out_x);
            end else begin
                due = distorted_due.pop_front();
                if (o_out_x !== due.x) report_mismatch("out_x", due.x, o_out_x);
                if (o_out_y !== due.y) report_mismatch("out_y", due.y, o_out_y);
                if (o_saturated !== due.sat) begin
                    report_mismatch("saturated", {31'd0, due.sat}, {31'd0, o_saturated});
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset leaves distortion off: points come back untouched, flag low.
    // Then keep enable clear with busy coefficients and check the same.
    task automatic test_reset_passthrough();
        t_lens_setting s;
        send_point(ldp_pkg::Q_MAX, ldp_pkg::Q_MIN);
        send_point(ldp_pkg::Q_MIN, ldp_pkg::Q_MAX);
        send_point(32'sd0, -32'sd1);
        send_point(32'sh5555_5555, 32'shaaaa_aaaa);
        drain();
        s = rand_setting(SET_WILD);
        s.enable = 1'b0;
        set_lens(s);
        send_point(q16(640), q16(-480));
        send_point(ldp_pkg::Q_MAX, ldp_pkg::Q_MAX);
    endtask

    // Radial scale around the origin: gentle, clipped after the radial step,
    // and saturating Horner sums in both directions.
    task automatic test_radial_scale();
        t_lens_setting s;
        s = '{default: 0};
        s.enable = 1'b1;
        s.k1 = 64'sd1 <<< 18;
        s.k2 = 64'sd1 <<< 30;
        s.k3 = -(64'sd1 <<< 42);
        drain();
        set_lens(s);
        send_point(q16(100), q16(-75));
        send_point(q16(2000), q16(1500));
        send_point(ldp_pkg::Q_MAX, ldp_pkg::Q_MIN);
        s.k1 = ldp_pkg::S64_MAX;
        s.k2 = ldp_pkg::S64_MAX;
        s.k3 = ldp_pkg::S64_MAX;
        drain();
        set_lens(s);
        send_point(q16(3), q16(4));
        send_point(q16(-1000), q16(20));
        s.k1 = ldp_pkg::S64_MIN;
        s.k2 = ldp_pkg::S64_MIN;
        s.k3 = ldp_pkg::S64_MIN;
        drain();
        set_lens(s);
        send_point(q16(500), q16(-500));
    endtask

    // Tangential terms alone, moderate and at full coefficient range.
    task automatic test_tangential_terms();
        t_lens_setting s;
        s = '{default: 0};
        s.enable = 1'b1;
        s.p1 = 64'sd1 <<< 20;
        s.p2 = -(64'sd1 <<< 20);
        drain();
        set_lens(s);
        send_point(q16(300), q16(200));
        send_point(q16(-2000), q16(1000));
        s.p1 = ldp_pkg::S64_MAX;
        s.p2 = ldp_pkg::S64_MIN;
        drain();
        set_lens(s);
        send_point(q16(1), q16(-1));
        send_point(ldp_pkg::Q_MAX, ldp_pkg::Q_MAX);
    endtask

    // Centre at the corners of the range: widest possible distance terms.
    task automatic test_centre_offsets();
        t_lens_setting s;
        s = '{default: 0};
        s.enable = 1'b1;
        s.cx = ldp_pkg::Q_MAX;
        s.cy = ldp_pkg::Q_MIN;
        s.k1 = 64'sd1;
        drain();
        set_lens(s);
        send_point(ldp_pkg::Q_MIN, ldp_pkg::Q_MAX);
        send_point(ldp_pkg::Q_MAX, ldp_pkg::Q_MIN);
        s.cx = ldp_pkg::Q_MIN;
        s.cy = ldp_pkg::Q_MAX;
        drain();
        set_lens(s);
        send_point(ldp_pkg::Q_MAX, ldp_pkg::Q_MIN);
        send_point(32'sd0, 32'sd0);
    endtask

    // One random stream per kind of setting, draining before each rewrite.
    task automatic test_random_stream(input int idle_pct);
        sender_idle_pct = idle_pct;
        for (int kind = SET_OFF; kind <= SET_WILD; kind++) begin
            drain();
            set_lens(rand_setting(t_setting_kind'(kind)));
            repeat (95) send_point(rand_coord(), rand_coord());
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_point_x       = '0;
        i_point_y       = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = ldp_pkg::CFG_ENABLE;
        i_cfg_data      = '0;
        lens            = '{default: 0};
        fail_count      = 0;
        sender_idle_pct = 13;

        // Hold reset low, then release it for good
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_passthrough();
        test_radial_scale();
        test_tangential_terms();
        test_centre_offsets();
        test_random_stream(13);
        test_random_stream(50);
        test_random_stream(0);

        // Wait out the pipeline so a stray extra beat is caught
        drain();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
